// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the settings controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CBSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another at the next clock edge.
`define CBSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cbsc_pkg.sv -----
// Types, constants and step functions of the clock button settings controller.
package cbsc_pkg;

  typedef enum logic [1:0] {
    MODE_DISPLAY = 2'd0,
    MODE_VALUE   = 2'd1,
    MODE_BRIGHT  = 2'd2,
    MODE_COLOUR  = 2'd3
  } mode_e;

  // Button bit positions in the masks.
  localparam int unsigned BtnUp   = 0;
  localparam int unsigned BtnSel  = 1;
  localparam int unsigned BtnDown = 2;
  localparam int unsigned BtnBc   = 3;

  localparam logic [1:0] PartHours   = 2'd0;
  localparam logic [1:0] PartMinutes = 2'd1;
  localparam logic [1:0] PartSeconds = 2'd2;

  localparam logic [7:0] RepeatSteady  = 8'd37;
  localparam logic [7:0] RepeatMax     = 8'd255;
  localparam logic [6:0] HourWrap      = 7'd12;
  localparam logic [6:0] MinSecWrap    = 7'd60;
  localparam logic [7:0] BrightDefault = 8'd200;
  localparam logic [7:0] BrightRepeat  = 8'd2;
  localparam logic [3:0] ColourCount   = 4'd5;

  localparam logic [2:0] ColourBlue  = 3'd0;
  localparam logic [2:0] ColourGreen = 3'd1;
  localparam logic [2:0] ColourRed   = 3'd2;

  typedef logic [2:0][2:0] colours_t;
  typedef logic [2:0][7:0] bright_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } edit_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic [1:0]  selected_part;
    logic [4:0]  shown_hours;
    logic [5:0]  shown_minutes;
    logic [5:0]  shown_seconds;
    logic        refresh_display;
    logic        commit_strobe;
    colours_t    colours_packed;
    bright_t     brightness_packed;
  } result_t;

  // Selection 3 acts as hours.
  function automatic logic [1:0] part_idx(logic [1:0] sel);
    return (sel > PartSeconds) ? PartHours : sel;
  endfunction

  function automatic logic [1:0] next_sel(logic [1:0] sel);
    logic [1:0] r;
    case (sel)
      PartHours:   r = PartMinutes;
      PartMinutes: r = PartSeconds;
      default:     r = PartHours;
    endcase
    return r;
  endfunction

  function automatic logic repeat_fire(logic [7:0] n);
    return (n inside {8'd5, 8'd10, 8'd14, 8'd18, 8'd21, 8'd24, 8'd27, 8'd29, 8'd31,
                      8'd33, 8'd35}) || (n >= RepeatSteady);
  endfunction

  // One wrap step of a time component; out-of-range hours may need two folds.
  function automatic logic [5:0] time_step(logic [5:0] v, logic is_hour, logic up);
    logic [6:0] wrap;
    logic [6:0] s;
    wrap = is_hour ? HourWrap : MinSecWrap;
    if (up) begin
      s = {1'b0, v} + 7'd1;
      if (s >= (wrap << 1)) begin
        s = s - (wrap << 1);
      end else if (s >= wrap) begin
        s = s - wrap;
      end
    end else begin
      s = (v == 6'd0) ? (wrap - 7'd1) : ({1'b0, v} - 7'd1);
    end
    return s[5:0];
  endfunction

  function automatic edit_t apply_time(edit_t e, logic [1:0] idx, logic up);
    edit_t r;
    logic [5:0] t;
    r = e;
    case (idx)
      PartMinutes: r.minutes = time_step(e.minutes, 1'b0, up);
      PartSeconds: r.seconds = time_step(e.seconds, 1'b0, up);
      default: begin
        t = time_step({1'b0, e.hours}, 1'b1, up);
        r.hours = t[4:0];
      end
    endcase
    return r;
  endfunction

  // Step the ring and take the first colour no part holds; candidates are independent.
  function automatic colours_t colour_step(colours_t cols, logic [1:0] idx, logic up);
    colours_t r;
    logic [2:0] c;
    logic [3:0] s;
    logic [3:0] cand;
    logic [2:0] pick;
    logic       found;
    r = cols;
    c = cols[idx];
    // A code beyond the ring lands on white first.
    if ({1'b0, c} >= ColourCount) begin
      s = up ? 4'd3 : 4'd0;
    end else begin
      s = {1'b0, c};
    end
    found = 1'b0;
    pick = c;
    for (int k = 1; k <= 5; k++) begin
      cand = up ? (s + 4'(k)) : (s + ColourCount - 4'(k));
      if (cand >= ColourCount) begin
        cand = cand - ColourCount;
      end
      if (!found) begin
        pick = cand[2:0];
        if (cand[2:0] != cols[0] && cand[2:0] != cols[1] && cand[2:0] != cols[2]) begin
          found = 1'b1;
        end
      end
    end
    r[idx] = pick;
    return r;
  endfunction

endpackage

// ----- sv/clock_button_settings_controller.sv -----
// Top level of the clock button settings controller: tick stepping and result buffering.
//
// Usage: each request on the input channel is one user-interface tick with the
// qualified button masks and the real-time-clock time. The block answers every
// request with exactly one result: mode, selected part, the time to show, the
// refresh and commit strobes, and the packed colours and brightness values.
// Both channels are valid/ready; a request is taken when in_valid_i and
// in_ready_o are high at a rising edge, a result when out_valid_o and out_ready_i are.
// A result is registered into the output register, or into the skid register during a stall.
// Throughput: one request per cycle while in_ready_o is high; the whole tick
// step is one pass of combinational logic from the state registers into the result buffer.
// A two-entry result buffer (output register plus skid register) lets one more
// request in while a result waits; in_ready_o drops only when both are full,
// and rises again the cycle after the receiver takes a result.
// Reset (rst_ni low) returns display mode, hours selected, zero edit time,
// colours blue/green/red, brightness 200 on all parts, and an empty buffer.
module clock_button_settings_controller (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              buttons_down_i,
  input  logic [3:0]              buttons_long_i,
  input  logic                    select_pressed_i,
  input  logic [3:0]              released_short_i,
  input  logic [4:0]              clock_hours_i,
  input  logic [5:0]              clock_minutes_i,
  input  logic [5:0]              clock_seconds_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              mode_now_o,
  output logic [1:0]              selected_part_o,
  output logic [4:0]              shown_hours_o,
  output logic [5:0]              shown_minutes_o,
  output logic [5:0]              shown_seconds_o,
  output logic                    refresh_display_o,
  output logic                    commit_strobe_o,
  output cbsc_pkg::colours_t      colours_packed_o,
  output cbsc_pkg::bright_t       brightness_packed_o
);
  import cbsc_pkg::*;
  `include "assert_macros.svh"

  mode_e      mode_q, mode_d;
  logic       drs_q, drs_d;   // display release seen
  logic       srs_q, srs_d;   // settings release seen
  logic [1:0] sel_q, sel_d;
  logic [7:0] rc_q, rc_d;
  edit_t      edit_q, edit_d;
  colours_t   col_q, col_d;
  bright_t    bri_q, bri_d;

  result_t    res_d, out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       accept, take;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = out_valid_q && out_ready_i;

  always_comb begin
    logic [2:0] cnt;
    logic       refresh;
    logic       commit;
    mode_e      nxt;
    logic [1:0] idx;
    logic       fire;
    logic       up;
    logic [7:0] b;

    mode_d  = mode_q;
    drs_d   = drs_q;
    srs_d   = srs_q;
    sel_d   = sel_q;
    rc_d    = rc_q;
    edit_d  = edit_q;
    col_d   = col_q;
    bri_d   = bri_q;
    refresh = 1'b1;
    commit  = 1'b0;
    nxt     = mode_q;
    idx     = PartHours;
    fire    = 1'b0;
    up      = 1'b0;
    b       = 8'd0;
    cnt = {2'b00, buttons_down_i[0]} + {2'b00, buttons_down_i[1]}
        + {2'b00, buttons_down_i[2]} + {2'b00, buttons_down_i[3]};

    if (mode_q == MODE_DISPLAY) begin
      if (!drs_q) begin
        if (!buttons_down_i[BtnSel]) begin
          drs_d = 1'b1;
        end
      end else if (buttons_long_i[BtnSel]) begin
        refresh = 1'b0;
        mode_d  = MODE_VALUE;
        sel_d   = PartHours;
        rc_d    = 8'd0;
        srs_d   = 1'b0;
      end
      edit_d.hours   = clock_hours_i;
      edit_d.minutes = clock_minutes_i;
      edit_d.seconds = clock_seconds_i;
    end else if (!srs_q) begin
      if (!buttons_down_i[BtnSel]) begin
        srs_d = 1'b1;
      end
    end else if (buttons_long_i[BtnSel] && cnt == 3'd1) begin
      commit  = 1'b1;
      refresh = 1'b0;
      mode_d  = MODE_DISPLAY;
      drs_d   = 1'b0;
    end else begin
      if (mode_q == MODE_BRIGHT) begin
        if (!buttons_long_i[BtnBc]) begin
          rc_d = 8'd0;
          if (cnt == 3'd0) begin
            nxt = MODE_VALUE;
          end
        end else begin
          if (cnt == 3'd1) begin
            rc_d = 8'd0;
          end else if (select_pressed_i) begin
            sel_d = next_sel(sel_q);
          end else if (buttons_long_i[BtnUp] || buttons_long_i[BtnDown]) begin
            up   = buttons_long_i[BtnUp];
            rc_d = (rc_q != RepeatMax) ? rc_q + 8'd1 : rc_q;
            fire = repeat_fire(rc_d);
          end
          // Sum all brightness moves of this tick on the selected part.
          idx = part_idx(sel_d);
          b   = bri_q[idx];
          if (fire) begin
            b = up ? b + BrightRepeat : b - BrightRepeat;
          end
          if (released_short_i[BtnUp]) begin
            b = b + 8'd1;
          end
          if (released_short_i[BtnDown]) begin
            b = b - 8'd1;
          end
          bri_d[idx] = b;
        end
      end else if (cnt > 3'd1) begin
        rc_d = 8'd0;
      end else begin
        if (cnt == 3'd0) begin
          rc_d = 8'd0;
        end else if (buttons_long_i[BtnBc]) begin
          nxt = MODE_BRIGHT;
        end else if (select_pressed_i) begin
          sel_d = next_sel(sel_q);
        end else if (buttons_long_i[BtnUp] || buttons_long_i[BtnDown]) begin
          up   = buttons_long_i[BtnUp];
          rc_d = (rc_q != RepeatMax) ? rc_q + 8'd1 : rc_q;
          fire = repeat_fire(rc_d);
        end
        idx = part_idx(sel_d);
        if (released_short_i[BtnBc]) begin
          nxt = (mode_q == MODE_VALUE) ? MODE_COLOUR : MODE_VALUE;
        end
        // Apply the repeat step, then the short up, then the short down.
        if (mode_q == MODE_VALUE) begin
          if (fire) begin
            edit_d = apply_time(edit_d, idx, up);
          end
          if (released_short_i[BtnUp]) begin
            edit_d = apply_time(edit_d, idx, 1'b1);
          end
          if (released_short_i[BtnDown]) begin
            edit_d = apply_time(edit_d, idx, 1'b0);
          end
        end else begin
          if (fire) begin
            col_d = colour_step(col_d, idx, up);
          end
          if (released_short_i[BtnUp]) begin
            col_d = colour_step(col_d, idx, 1'b1);
          end
          if (released_short_i[BtnDown]) begin
            col_d = colour_step(col_d, idx, 1'b0);
          end
        end
      end
      if (nxt != mode_q) begin
        mode_d = nxt;
        rc_d   = 8'd0;
      end
    end

    res_d.mode_now          = mode_d;
    res_d.selected_part     = sel_d;
    res_d.shown_hours       = edit_d.hours;
    res_d.shown_minutes     = edit_d.minutes;
    res_d.shown_seconds     = edit_d.seconds;
    res_d.refresh_display   = refresh;
    res_d.commit_strobe     = commit;
    res_d.colours_packed    = col_d;
    res_d.brightness_packed = bri_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DISPLAY;
      drs_q  <= 1'b1;
      srs_q  <= 1'b1;
      sel_q  <= PartHours;
      rc_q   <= 8'd0;
      edit_q <= '0;
      col_q  <= {ColourRed, ColourGreen, ColourBlue};
      bri_q  <= {BrightDefault, BrightDefault, BrightDefault};
    end else if (accept) begin
      mode_q <= mode_d;
      drs_q  <= drs_d;
      srs_q  <= srs_d;
      sel_q  <= sel_d;
      rc_q   <= rc_d;
      edit_q <= edit_d;
      col_q  <= col_d;
      bri_q  <= bri_d;
    end
  end

  // Result buffer: output register in front, skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= accept;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (accept) begin
          skid_q <= res_d;
        end
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mode_now_o          = out_q.mode_now;
  assign selected_part_o     = out_q.selected_part;
  assign shown_hours_o       = out_q.shown_hours;
  assign shown_minutes_o     = out_q.shown_minutes;
  assign shown_seconds_o     = out_q.shown_seconds;
  assign refresh_display_o   = out_q.refresh_display;
  assign commit_strobe_o     = out_q.commit_strobe;
  assign colours_packed_o    = out_q.colours_packed;
  assign brightness_packed_o = out_q.brightness_packed;

  `CBSC_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full with output empty")
  `CBSC_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid_q && !out_ready_i, skid_valid_q,
                    "request taken during stall was not held in skid")
  `CBSC_ASSERT(a_commit_leaves, !(out_valid_q && out_q.commit_strobe) ||
               (out_q.mode_now == MODE_DISPLAY && !out_q.refresh_display),
               "commit without return to display mode")
  `CBSC_ASSERT_NEXT(a_enter_settings, accept && mode_q == MODE_DISPLAY && mode_d != MODE_DISPLAY,
                    sel_q == PartHours && !srs_q && rc_q == 8'd0,
                    "entering settings did not reset selection and release tracking")

endmodule

// ----- test/cbsc_tick_checker.sv -----
// Tick checker for the clock button settings controller: predicts every result and compares it.
`timescale 1ns / 1ps
module cbsc_tick_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [3:0]         buttons_down_i,
  input  logic [3:0]         buttons_long_i,
  input  logic               select_pressed_i,
  input  logic [3:0]         released_short_i,
  input  logic [4:0]         clock_hours_i,
  input  logic [5:0]         clock_minutes_i,
  input  logic [5:0]         clock_seconds_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         mode_now_i,
  input  logic [1:0]         selected_part_i,
  input  logic [4:0]         shown_hours_i,
  input  logic [5:0]         shown_minutes_i,
  input  logic [5:0]         shown_seconds_i,
  input  logic               refresh_display_i,
  input  logic               commit_strobe_i,
  input  cbsc_pkg::colours_t colours_packed_i,
  input  cbsc_pkg::bright_t  brightness_packed_i,
  output int                 errors_o,
  output int                 pending_o
);
  import cbsc_pkg::*;

  localparam logic [2:0] ColourWhite = 3'd4;

  // Shadow copy of the controller state.
  mode_e      mode_q;
  logic       display_armed_q;
  logic       settings_armed_q;
  logic [1:0] sel_q;
  logic [7:0] repeat_q;
  logic [4:0] hrs_q;
  logic [5:0] mins_q;
  logic [5:0] secs_q;
  colours_t   colours_q;
  bright_t    bright_q;

  result_t awaited_results[$];

  // An out-of-range selection edits the hours.
  function automatic logic [1:0] live_part();
    return (sel_q > PartSeconds) ? PartHours : sel_q;
  endfunction

  function automatic logic [1:0] following_part(logic [1:0] p);
    if (p == PartHours) return PartMinutes;
    if (p == PartMinutes) return PartSeconds;
    return PartHours;
  endfunction

  // Codes past the ring land on white.
  function automatic logic [2:0] ring_colour(logic [2:0] c, logic up);
    if ({1'b0, c} >= ColourCount) return ColourWhite;
    if (up) return (c == ColourWhite) ? ColourBlue : c + 3'd1;
    return (c == ColourBlue) ? ColourWhite : c - 3'd1;
  endfunction

  task automatic clear_state();
    mode_q           = MODE_DISPLAY;
    display_armed_q  = 1'b1;
    settings_armed_q = 1'b1;
    sel_q            = PartHours;
    repeat_q         = '0;
    hrs_q            = '0;
    mins_q           = '0;
    secs_q           = '0;
    colours_q[0]     = ColourBlue;
    colours_q[1]     = ColourGreen;
    colours_q[2]     = ColourRed;
    bright_q[0]      = BrightDefault;
    bright_q[1]      = BrightDefault;
    bright_q[2]      = BrightDefault;
  endtask

  // Advance the auto-repeat counter and tell whether this tick fires a step.
  task automatic count_repeat(output logic fire);
    if (repeat_q != RepeatMax) repeat_q = repeat_q + 8'd1;
    case (repeat_q)
      8'd5, 8'd10, 8'd14, 8'd18, 8'd21, 8'd24, 8'd27, 8'd29, 8'd31, 8'd33, 8'd35: fire = 1'b1;
      default: fire = (repeat_q >= RepeatSteady);
    endcase
  endtask

  task automatic nudge_time(input logic up);
    logic [1:0] p;
    logic [6:0] wrap;
    logic [6:0] v;
    p = live_part();
    wrap = (p == PartHours) ? HourWrap : MinSecWrap;
    case (p)
      PartMinutes: v = {1'b0, mins_q};
      PartSeconds: v = {1'b0, secs_q};
      default:     v = {2'b00, hrs_q};
    endcase
    if (up) begin
      v = (v + 7'd1) % wrap;
    end else begin
      v = (v == 7'd0) ? wrap - 7'd1 : v - 7'd1;
    end
    case (p)
      PartMinutes: mins_q = v[5:0];
      PartSeconds: secs_q = v[5:0];
      default:     hrs_q = v[4:0];
    endcase
  endtask

  task automatic nudge_bright(input logic [7:0] delta, input logic up);
    logic [1:0] p;
    p = live_part();
    bright_q[p] = up ? bright_q[p] + delta : bright_q[p] - delta;
  endtask

  // Walk the ring until a colour no part holds turns up, five tries at most.
  task automatic nudge_colour(input logic up);
    logic [1:0] p;
    logic [2:0] c;
    logic       free;
    p = live_part();
    c = colours_q[p];
    free = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (!free) begin
        c = ring_colour(c, up);
        free = (c != colours_q[0]) && (c != colours_q[1]) && (c != colours_q[2]);
      end
    end
    colours_q[p] = c;
  endtask

  task automatic nudge_part(input logic up);
    if (mode_q == MODE_VALUE) nudge_time(up);
    else nudge_colour(up);
  endtask

  task automatic edit_tick(input logic [3:0] dn, input logic [3:0] lg, input logic sp,
                           input logic [3:0] rs, output mode_e nxt);
    int unsigned held;
    logic        fire;
    held = $countones(dn);
    nxt = mode_q;
    if (mode_q == MODE_BRIGHT) begin
      if (!lg[BtnBc]) begin
        repeat_q = '0;
        if (held == 0) nxt = MODE_VALUE;
      end else begin
        if (held == 1) begin
          repeat_q = '0;
        end else if (sp) begin
          sel_q = following_part(sel_q);
        end else if (lg[BtnUp]) begin
          count_repeat(fire);
          if (fire) nudge_bright(BrightRepeat, 1'b1);
        end else if (lg[BtnDown]) begin
          count_repeat(fire);
          if (fire) nudge_bright(BrightRepeat, 1'b0);
        end
        if (rs[BtnUp]) nudge_bright(8'd1, 1'b1);
        if (rs[BtnDown]) nudge_bright(8'd1, 1'b0);
      end
    end else if (held > 1) begin
      repeat_q = '0;
    end else begin
      if (held == 0) begin
        repeat_q = '0;
      end else if (lg[BtnBc]) begin
        nxt = MODE_BRIGHT;
      end else if (sp) begin
        sel_q = following_part(sel_q);
      end else if (lg[BtnUp] || lg[BtnDown]) begin
        count_repeat(fire);
        if (fire) nudge_part(lg[BtnUp]);
      end
      if (rs[BtnBc]) nxt = (mode_q == MODE_VALUE) ? MODE_COLOUR : MODE_VALUE;
      if (rs[BtnUp]) nudge_part(1'b1);
      if (rs[BtnDown]) nudge_part(1'b0);
    end
  endtask

  task automatic predict_tick(output result_t r);
    mode_e nxt;
    logic  refresh;
    logic  commit;
    refresh = 1'b1;
    commit = 1'b0;
    if (mode_q == MODE_DISPLAY) begin
      if (!display_armed_q) begin
        if (!buttons_down_i[BtnSel]) display_armed_q = 1'b1;
      end else if (buttons_long_i[BtnSel]) begin
        refresh = 1'b0;
        mode_q = MODE_VALUE;
        sel_q = PartHours;
        repeat_q = '0;
        settings_armed_q = 1'b0;
      end
      hrs_q = clock_hours_i;
      mins_q = clock_minutes_i;
      secs_q = clock_seconds_i;
    end else if (!settings_armed_q) begin
      if (!buttons_down_i[BtnSel]) settings_armed_q = 1'b1;
    end else if (buttons_long_i[BtnSel] && $countones(buttons_down_i) == 1) begin
      commit = 1'b1;
      refresh = 1'b0;
      mode_q = MODE_DISPLAY;
      display_armed_q = 1'b0;
    end else begin
      edit_tick(buttons_down_i, buttons_long_i, select_pressed_i, released_short_i, nxt);
      if (nxt != mode_q) begin
        mode_q = nxt;
        repeat_q = '0;
      end
    end
    r.mode_now          = mode_q;
    r.selected_part     = sel_q;
    r.shown_hours       = hrs_q;
    r.shown_minutes     = mins_q;
    r.shown_seconds     = secs_q;
    r.refresh_display   = refresh;
    r.commit_strobe     = commit;
    r.colours_packed    = colours_q;
    r.brightness_packed = bright_q;
  endtask

  task automatic match_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_o++;
    end
  endtask

  // Compare before predicting: a result leaving now belongs to an earlier request.
  always @(posedge clk_i) begin : watch
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      clear_state();
      awaited_results.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request pending");
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          match_field("mode_now", 24'(want.mode_now), 24'(mode_now_i));
          match_field("selected_part", 24'(want.selected_part), 24'(selected_part_i));
          match_field("shown_hours", 24'(want.shown_hours), 24'(shown_hours_i));
          match_field("shown_minutes", 24'(want.shown_minutes), 24'(shown_minutes_i));
          match_field("shown_seconds", 24'(want.shown_seconds), 24'(shown_seconds_i));
          match_field("refresh_display", 24'(want.refresh_display), 24'(refresh_display_i));
          match_field("commit_strobe", 24'(want.commit_strobe), 24'(commit_strobe_i));
          match_field("colours_packed", 24'(want.colours_packed), 24'(colours_packed_i));
          match_field("brightness_packed", 24'(want.brightness_packed),
                      24'(brightness_packed_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_tick(fresh);
        awaited_results.push_back(fresh);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- test/clock_button_settings_controller_tb.sv -----
// Testbench top of the clock button settings controller: tick stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module clock_button_settings_controller_tb;
  import cbsc_pkg::*;

  localparam int unsigned TickTarget    = 1850;
  localparam int unsigned PhaseLength   = 200;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;

  localparam logic [3:0] MaskNone = 4'b0000;
  localparam logic [3:0] MaskUp   = 4'b0001 << BtnUp;
  localparam logic [3:0] MaskSel  = 4'b0001 << BtnSel;
  localparam logic [3:0] MaskDown = 4'b0001 << BtnDown;
  localparam logic [3:0] MaskBc   = 4'b0001 << BtnBc;

  typedef struct packed {
    logic [3:0] down;
    logic [3:0] held_long;
    logic       sel_new;
    logic [3:0] short_rel;
    logic [4:0] hrs;
    logic [5:0] mins;
    logic [5:0] secs;
  } tick_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [3:0] down = '0;
  logic [3:0] held_long = '0;
  logic       sel_new = 1'b0;
  logic [3:0] short_rel = '0;
  logic [4:0] hrs = '0;
  logic [5:0] mins = '0;
  logic [5:0] secs = '0;
  logic       out_ready = 1'b0;

  logic       in_ready;
  logic       out_valid;
  logic [1:0] mode_now;
  logic [1:0] selected_part;
  logic [4:0] shown_hours;
  logic [5:0] shown_minutes;
  logic [5:0] shown_seconds;
  logic       refresh_display;
  logic       commit_strobe;
  colours_t   colours_packed;
  bright_t    brightness_packed;

  int errors;
  int pending;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int directed_count = 0;

  tick_t ticks[$];

  always #2 clk = ~clk;

  clock_button_settings_controller dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .buttons_down_i      (down),
    .buttons_long_i      (held_long),
    .select_pressed_i    (sel_new),
    .released_short_i    (short_rel),
    .clock_hours_i       (hrs),
    .clock_minutes_i     (mins),
    .clock_seconds_i     (secs),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .mode_now_o          (mode_now),
    .selected_part_o     (selected_part),
    .shown_hours_o       (shown_hours),
    .shown_minutes_o     (shown_minutes),
    .shown_seconds_o     (shown_seconds),
    .refresh_display_o   (refresh_display),
    .commit_strobe_o     (commit_strobe),
    .colours_packed_o    (colours_packed),
    .brightness_packed_o (brightness_packed)
  );

  cbsc_tick_checker checker_i (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .buttons_down_i      (down),
    .buttons_long_i      (held_long),
    .select_pressed_i    (sel_new),
    .released_short_i    (short_rel),
    .clock_hours_i       (hrs),
    .clock_minutes_i     (mins),
    .clock_seconds_i     (secs),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .mode_now_i          (mode_now),
    .selected_part_i     (selected_part),
    .shown_hours_i       (shown_hours),
    .shown_minutes_i     (shown_minutes),
    .shown_seconds_i     (shown_seconds),
    .refresh_display_i   (refresh_display),
    .commit_strobe_i     (commit_strobe),
    .colours_packed_i    (colours_packed),
    .brightness_packed_i (brightness_packed),
    .errors_o            (errors),
    .pending_o           (pending)
  );

  task automatic queue_tick_at(input logic [3:0] dn, input logic [3:0] lg, input logic sp,
                               input logic [3:0] rs, input logic [4:0] h, input logic [5:0] m,
                               input logic [5:0] s);
    tick_t t;
    t.down      = dn;
    t.held_long = lg;
    t.sel_new   = sp;
    t.short_rel = rs;
    t.hrs       = h;
    t.mins      = m;
    t.secs      = s;
    ticks.push_back(t);
  endtask

  // Mostly a sane clock time; now and then any value the field holds.
  task automatic queue_tick(input logic [3:0] dn, input logic [3:0] lg, input logic sp,
                            input logic [3:0] rs);
    if ($urandom_range(7) == 0) begin
      queue_tick_at(dn, lg, sp, rs, 5'($urandom), 6'($urandom), 6'($urandom));
    end else begin
      queue_tick_at(dn, lg, sp, rs, 5'($urandom_range(23)), 6'($urandom_range(59)),
                    6'($urandom_range(59)));
    end
  endtask

  task automatic queue_hold(input logic [3:0] base, input logic [3:0] dir);
    int unsigned n;
    n = ($urandom_range(19) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 45);
    repeat ($urandom_range(3)) queue_tick(base | dir, base, 1'b0, MaskNone);
    repeat (n) queue_tick(base | dir, base | dir, 1'b0, MaskNone);
  endtask

  // Append one button gesture: mostly well-formed, some noise.
  task automatic queue_gesture();
    logic [3:0] dir;
    dir = $urandom_range(1) ? MaskUp : MaskDown;
    case ($urandom_range(11))
      0, 1: begin
        repeat ($urandom_range(1, 3)) queue_tick(MaskSel, MaskSel, 1'b0, MaskNone);
        queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
      end
      2: begin
        repeat ($urandom_range(1, 2)) queue_tick(MaskSel, MaskSel, 1'b0, MaskNone);
        queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
      end
      3, 4: begin
        queue_hold(MaskNone, dir);
        queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
      end
      5, 6: begin
        case ($urandom_range(3))
          0: queue_tick(MaskNone, MaskNone, 1'b0, MaskBc);
          1: queue_tick(MaskNone, MaskNone, 1'b0, 4'($urandom));
          default: queue_tick(MaskNone, MaskNone, 1'b0, dir);
        endcase
      end
      7: begin
        queue_tick(MaskSel, MaskNone, 1'b1, MaskNone);
        queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
      end
      8, 9: begin
        repeat ($urandom_range(1, 2)) queue_tick(MaskBc, MaskBc, 1'b0, MaskNone);
        repeat ($urandom_range(1, 6)) begin
          dir = $urandom_range(1) ? MaskUp : MaskDown;
          case ($urandom_range(3))
            0: queue_hold(MaskBc, dir);
            1: queue_tick(MaskBc, MaskBc, 1'b0, $urandom_range(3) == 0 ? MaskUp | MaskDown : dir);
            2: queue_tick(MaskBc | MaskSel, MaskBc, 1'b1, MaskNone);
            default: queue_tick(MaskBc, MaskBc, 1'b0, MaskNone);
          endcase
        end
        queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
      end
      default: begin
        repeat ($urandom_range(1, 4)) begin
          queue_tick(4'($urandom), 4'($urandom), 1'($urandom), 4'($urandom));
        end
      end
    endcase
  endtask

  task automatic offer_tick(input tick_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    down      <= t.down;
    held_long <= t.held_long;
    sel_new   <= t.sel_new;
    short_rel <= t.short_rel;
    hrs       <= t.hrs;
    mins      <= t.mins;
    secs      <= t.secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: hold off long enough to back the block up, then stall per phase.
  initial begin
    wait (rst_n);
    repeat (HoldOffCycles) @(posedge clk);
    forever begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      @(posedge clk);
    end
  end

  initial begin
    int phase;
    // Out-of-range clock time passes through, then enters edit mode.
    queue_tick_at(MaskNone, MaskNone, 1'b0, MaskNone, 5'd31, 6'd63, 6'd63);
    queue_tick_at(MaskSel, MaskSel, 1'b0, MaskNone, 5'd31, 6'd63, 6'd63);
    queue_tick_at(MaskSel, MaskSel, 1'b0, MaskNone, 5'd0, 6'd0, 6'd0);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskUp);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskDown);
    queue_tick(MaskSel, MaskNone, 1'b1, MaskNone);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskUp);
    queue_tick(MaskSel, MaskNone, 1'b1, MaskNone);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskDown);
    queue_tick(MaskSel, MaskNone, 1'b1, MaskNone);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskBc);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskUp);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskDown);
    queue_tick(MaskBc, MaskBc, 1'b0, MaskNone);
    repeat (5) queue_tick(MaskBc | MaskUp, MaskBc | MaskUp, 1'b0, MaskNone);
    queue_tick(MaskBc, MaskBc, 1'b0, MaskDown);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
    // Two buttons down blocks the exit; one commits.
    queue_tick(MaskSel | MaskUp, MaskSel, 1'b0, MaskNone);
    queue_tick(MaskSel, MaskSel, 1'b0, MaskNone);
    queue_tick(MaskNone, MaskNone, 1'b0, MaskNone);
    directed_count = ticks.size();
    while (ticks.size() < directed_count + TickTarget) queue_gesture();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < ticks.size(); i++) begin
      if (i >= directed_count) begin
        phase = ((i - directed_count) / PhaseLength) % 4;
        sender_idle_pct = (phase == 1) ? 75 : (phase == 3) ? 10 : 0;
        receiver_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 10 : 0;
      end
      offer_tick(ticks[i]);
    end
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- clock_button_settings_controller.f -----
+incdir+sv
sv/cbsc_pkg.sv
sv/clock_button_settings_controller.sv
test/cbsc_tick_checker.sv
test/clock_button_settings_controller_tb.sv
